// ===== design/calendar_seconds_converter_top_assert.svh =====
// Assertion macros for the calendar seconds converter.
// Each macro expects i_clk and i_rst_n in scope at the point of use.
`ifndef CALENDAR_SECONDS_CONVERTER_TOP_ASSERT_SVH
`define CALENDAR_SECONDS_CONVERTER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

`define CSC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define CSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CSC_ASSERT_SAME(lbl, ante, cons, msg)

`define CSC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/csc_pkg.sv =====
`default_nettype none

package csc_pkg;

    // field widths
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned YEAR_W  = 7;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;

    // internal widths
    localparam int unsigned DAYS_W  = 16;  // day index, also for years up to 127
    localparam int unsigned SOD_W   = 17;  // second of day
    localparam int unsigned MOD_W   = 11;  // minute of day
    localparam int unsigned DOQ_W   = 11;  // day within a four-year cycle
    localparam int unsigned DOY_W   = 9;   // day of year
    localparam int unsigned QUAD_W  = 6;   // four-year cycle index

    localparam int unsigned MONTHS  = 12;
    localparam int unsigned PIPE_STAGES = 5;

    localparam logic [16:0]      SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0]      SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]       SECS_PER_MIN  = 6'd60;
    localparam logic [5:0]       MINS_PER_HOUR = 6'd60;
    localparam logic [8:0]       DAYS_PER_YEAR = 9'd365;
    localparam logic [10:0]      DAYS_PER_QUAD = 11'd1461;
    localparam logic [DOY_W-1:0] MAX_DAY_IDX   = 9'd30;

    // 86400 = 2^7 * 675: shift first, then divide the upper part by 675
    localparam int unsigned DAY_SHIFT = 7;
    localparam int unsigned DAY_HI_W  = CNT_W - DAY_SHIFT;
    localparam int unsigned SOD_HI_W  = SOD_W - DAY_SHIFT;
    localparam logic [9:0]  DAY_ODD   = 10'd675;

    // reciprocals: floor(x / d) = (x * M) >> K for every x of the given width
    localparam int unsigned D675_K    = 35;
    localparam int unsigned D675_M_W  = 26;
    localparam logic [D675_M_W-1:0] D675_M =
        D675_M_W'(((64'd1 << D675_K) + 64'd674) / 64'd675);

    localparam int unsigned D1461_K   = 27;
    localparam int unsigned D1461_M_W = 17;
    localparam logic [D1461_M_W-1:0] D1461_M =
        D1461_M_W'(((64'd1 << D1461_K) + 64'd1460) / 64'd1461);

    localparam int unsigned D3600_K   = 29;
    localparam int unsigned D3600_M_W = 18;
    localparam logic [D3600_M_W-1:0] D3600_M =
        D3600_M_W'(((64'd1 << D3600_K) + 64'd3599) / 64'd3600);

    localparam int unsigned D60_K     = 23;
    localparam int unsigned D60_M_W   = 18;
    localparam logic [D60_M_W-1:0] D60_M =
        D60_M_W'(((64'd1 << D60_K) + 64'd59) / 64'd60);

    typedef enum logic {
        OP_DATE_TO_COUNT = 1'b0,
        OP_COUNT_TO_DATE = 1'b1
    } t_op;

    typedef struct packed {
        logic [PIPE_STAGES-1:0] load;
        logic [PIPE_STAGES-1:0] vld;
    } t_pipe_ctl;

    // days in the months before month index m0 (0 = January)
    function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m0,
                                                  input logic leap);
        logic [DOY_W-1:0] base;
        case (m0)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base + DOY_W'(leap && (m0 >= 4'd2));
    endfunction

endpackage

`default_nettype wire

// ===== design/csc_if.sv =====
`default_nettype none

interface csc_req_if import csc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [YEAR_W-1:0]    in_year;
    logic [MONTH_W-1:0]   in_month;
    logic [DAY_W-1:0]     in_day;
    logic [HOUR_W-1:0]    in_hour;
    logic [MIN_W-1:0]     in_minute;
    logic [SEC_W-1:0]     in_second;
    logic [CNT_W-1:0]     in_seconds_count;

    modport source (
        output valid, operation, in_year, in_month, in_day, in_hour, in_minute,
               in_second, in_seconds_count,
        input  ready
    );
    modport sink (
        input  valid, operation, in_year, in_month, in_day, in_hour, in_minute,
               in_second, in_seconds_count,
        output ready
    );
endinterface

interface csc_rsp_if import csc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CNT_W-1:0]     out_seconds_count;
    logic [YEAR_W-1:0]    out_year;
    logic [MONTH_W-1:0]   out_month;
    logic [DAY_W-1:0]     out_day;
    logic [HOUR_W-1:0]    out_hour;
    logic [MIN_W-1:0]     out_minute;
    logic [SEC_W-1:0]     out_second;
    logic                 out_range_error;

    modport source (
        output valid, out_seconds_count, out_year, out_month, out_day, out_hour,
               out_minute, out_second, out_range_error,
        input  ready
    );
    modport sink (
        input  valid, out_seconds_count, out_year, out_month, out_day, out_hour,
               out_minute, out_second, out_range_error,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/calendar_seconds_converter_top.sv =====
// Converts a calendar date-time to seconds since the start of year 0 of a
// century (operation 0) or seconds back to a date-time (operation 1), with
// every year divisible by four taken as leap. One beat is accepted per clock
// while the output side keeps taking beats, and each beat gives exactly one
// result beat; beats pass through the five-register pipeline (input register,
// three working stages, output register), across which the divisions by the
// day, the four-year cycle, the hour and the minute are done as reciprocal
// multiplications and back-subtractions. When the output stalls the pipeline
// fills and input ready drops only once all five stages hold a beat. Counts
// beyond the last second of year CENTURY_YEARS-1 raise out_range_error and
// saturate to that second.

`default_nettype none

`include "calendar_seconds_converter_top_assert.svh"

module calendar_seconds_converter_top import csc_pkg::*; #(
    parameter int unsigned CENTURY_YEARS = 100
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    csc_req_if.sink      i_req,
    csc_rsp_if.source    o_rsp
);

    localparam longint unsigned TotalDays =
        64'(CENTURY_YEARS) * 64'd365 + (64'(CENTURY_YEARS) + 64'd3) / 64'd4;
    localparam logic [CNT_W-1:0] LAST_SEC = CNT_W'(TotalDays * 64'd86400 - 64'd1);

    t_pipe_ctl ctl;

    csc_flow u_flow (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .o_ctl       (ctl)
    );

    assign i_req.ready = ctl.load[0];
    assign o_rsp.valid = ctl.vld[PIPE_STAGES-1];

    // ---------------- stage 0: input register
    t_op                r_s0_op;
    logic [YEAR_W-1:0]  r_s0_year;
    logic [MONTH_W-1:0] r_s0_month;
    logic [DAY_W-1:0]   r_s0_day;
    logic [HOUR_W-1:0]  r_s0_hour;
    logic [MIN_W-1:0]   r_s0_minute;
    logic [SEC_W-1:0]   r_s0_second;
    logic [CNT_W-1:0]   r_s0_cnt;

    always_ff @(posedge i_clk) begin
        if (ctl.load[0]) begin
            r_s0_op     <= t_op'(i_req.operation);
            r_s0_year   <= i_req.in_year;
            r_s0_month  <= i_req.in_month;
            r_s0_day    <= i_req.in_day;
            r_s0_hour   <= i_req.in_hour;
            r_s0_minute <= i_req.in_minute;
            r_s0_second <= i_req.in_second;
            r_s0_cnt    <= i_req.in_seconds_count;
        end
    end

    // ---------------- stage 1: date count, clamp, day index
    logic [CNT_W-1:0]              n_s1_count;
    logic                          n_s1_over;
    logic [CNT_W-1:0]              n_s1_cnt;
    logic [DAYS_W-1:0]             n_s1_days;
    logic [DAY_HI_W+D675_M_W-1:0]  a_prod;

    csc_date_count u_date_count (
        .i_year   (r_s0_year),
        .i_month  (r_s0_month),
        .i_day    (r_s0_day),
        .i_hour   (r_s0_hour),
        .i_minute (r_s0_minute),
        .i_second (r_s0_second),
        .o_count  (n_s1_count)
    );

    assign n_s1_over = (r_s0_cnt > LAST_SEC);
    assign n_s1_cnt  = n_s1_over ? LAST_SEC : r_s0_cnt;
    assign a_prod    = (DAY_HI_W + D675_M_W)'(n_s1_cnt[CNT_W-1:DAY_SHIFT])
                     * (DAY_HI_W + D675_M_W)'(D675_M);
    assign n_s1_days = a_prod[D675_K +: DAYS_W];

    t_op                r_s1_op;
    logic [CNT_W-1:0]   r_s1_count;
    logic               r_s1_over;
    logic [CNT_W-1:0]   r_s1_cnt;
    logic [DAYS_W-1:0]  r_s1_days;

    always_ff @(posedge i_clk) begin
        if (ctl.load[1]) begin
            r_s1_op    <= r_s0_op;
            r_s1_count <= n_s1_count;
            r_s1_over  <= n_s1_over;
            r_s1_cnt   <= n_s1_cnt;
            r_s1_days  <= n_s1_days;
        end
    end

    // ---------------- stage 2: second of day, four-year cycle
    logic [DAY_HI_W-1:0]            b_day_part;
    logic [SOD_W-1:0]               n_s2_sod;
    logic [DAYS_W+D1461_M_W-1:0]    b_qprod;
    logic [QUAD_W-1:0]              n_s2_quad;

    assign b_day_part = DAY_HI_W'(r_s1_days) * DAY_HI_W'(DAY_ODD);
    assign n_s2_sod   = {SOD_HI_W'(r_s1_cnt[CNT_W-1:DAY_SHIFT] - b_day_part),
                         r_s1_cnt[DAY_SHIFT-1:0]};
    assign b_qprod    = (DAYS_W + D1461_M_W)'(r_s1_days) * (DAYS_W + D1461_M_W)'(D1461_M);
    assign n_s2_quad  = b_qprod[D1461_K +: QUAD_W];

    t_op                r_s2_op;
    logic [CNT_W-1:0]   r_s2_count;
    logic               r_s2_over;
    logic [DAYS_W-1:0]  r_s2_days;
    logic [SOD_W-1:0]   r_s2_sod;
    logic [QUAD_W-1:0]  r_s2_quad;

    always_ff @(posedge i_clk) begin
        if (ctl.load[2]) begin
            r_s2_op    <= r_s1_op;
            r_s2_count <= r_s1_count;
            r_s2_over  <= r_s1_over;
            r_s2_days  <= r_s1_days;
            r_s2_sod   <= n_s2_sod;
            r_s2_quad  <= n_s2_quad;
        end
    end

    // ---------------- stage 3: day in cycle, hour, minute of day
    logic [DAYS_W-1:0]             c_qdays;
    logic [DOQ_W-1:0]              n_s3_doq;
    logic [SOD_W+D3600_M_W-1:0]    c_hprod;
    logic [SOD_W+D60_M_W-1:0]      c_mprod;
    logic [HOUR_W-1:0]             n_s3_hour;
    logic [MOD_W-1:0]              n_s3_mod;

    assign c_qdays   = DAYS_W'(r_s2_quad) * DAYS_W'(DAYS_PER_QUAD);
    assign n_s3_doq  = DOQ_W'(r_s2_days - c_qdays);
    assign c_hprod   = (SOD_W + D3600_M_W)'(r_s2_sod) * (SOD_W + D3600_M_W)'(D3600_M);
    assign n_s3_hour = c_hprod[D3600_K +: HOUR_W];
    assign c_mprod   = (SOD_W + D60_M_W)'(r_s2_sod) * (SOD_W + D60_M_W)'(D60_M);
    assign n_s3_mod  = c_mprod[D60_K +: MOD_W];

    t_op                r_s3_op;
    logic [CNT_W-1:0]   r_s3_count;
    logic               r_s3_over;
    logic [SOD_W-1:0]   r_s3_sod;
    logic [QUAD_W-1:0]  r_s3_quad;
    logic [DOQ_W-1:0]   r_s3_doq;
    logic [HOUR_W-1:0]  r_s3_hour;
    logic [MOD_W-1:0]   r_s3_mod;

    always_ff @(posedge i_clk) begin
        if (ctl.load[3]) begin
            r_s3_op    <= r_s2_op;
            r_s3_count <= r_s2_count;
            r_s3_over  <= r_s2_over;
            r_s3_sod   <= r_s2_sod;
            r_s3_quad  <= r_s2_quad;
            r_s3_doq   <= n_s3_doq;
            r_s3_hour  <= n_s3_hour;
            r_s3_mod   <= n_s3_mod;
        end
    end

    // ---------------- stage 4: calendar fields, output register
    logic [YEAR_W-1:0]  d_year;
    logic [MONTH_W-1:0] d_month;
    logic [DAY_W-1:0]   d_day;
    logic [MIN_W-1:0]   d_minute;
    logic [SEC_W-1:0]   d_second;

    csc_day_split u_day_split (
        .i_quad  (r_s3_quad),
        .i_doq   (r_s3_doq),
        .o_year  (d_year),
        .o_month (d_month),
        .o_day   (d_day)
    );

    assign d_minute = MIN_W'(r_s3_mod - MOD_W'(r_s3_hour) * MOD_W'(MINS_PER_HOUR));
    assign d_second = SEC_W'(r_s3_sod - SOD_W'(r_s3_mod) * SOD_W'(SECS_PER_MIN));

    logic [CNT_W-1:0]   n_s4_count;
    logic [YEAR_W-1:0]  n_s4_year;
    logic [MONTH_W-1:0] n_s4_month;
    logic [DAY_W-1:0]   n_s4_day;
    logic [HOUR_W-1:0]  n_s4_hour;
    logic [MIN_W-1:0]   n_s4_minute;
    logic [SEC_W-1:0]   n_s4_second;
    logic               n_s4_over;

    // zero the fields the other direction does not produce
    always_comb begin
        n_s4_count  = '0;
        n_s4_year   = '0;
        n_s4_month  = '0;
        n_s4_day    = '0;
        n_s4_hour   = '0;
        n_s4_minute = '0;
        n_s4_second = '0;
        n_s4_over   = 1'b0;
        case (r_s3_op)
            OP_DATE_TO_COUNT: begin
                n_s4_count = r_s3_count;
            end
            OP_COUNT_TO_DATE: begin
                n_s4_year   = d_year;
                n_s4_month  = d_month;
                n_s4_day    = d_day;
                n_s4_hour   = r_s3_hour;
                n_s4_minute = d_minute;
                n_s4_second = d_second;
                n_s4_over   = r_s3_over;
            end
            default: begin
                n_s4_count = '0;
            end
        endcase
    end

    logic [CNT_W-1:0]   r_s4_count;
    logic [YEAR_W-1:0]  r_s4_year;
    logic [MONTH_W-1:0] r_s4_month;
    logic [DAY_W-1:0]   r_s4_day;
    logic [HOUR_W-1:0]  r_s4_hour;
    logic [MIN_W-1:0]   r_s4_minute;
    logic [SEC_W-1:0]   r_s4_second;
    logic               r_s4_over;

    always_ff @(posedge i_clk) begin
        if (ctl.load[4]) begin
            r_s4_count  <= n_s4_count;
            r_s4_year   <= n_s4_year;
            r_s4_month  <= n_s4_month;
            r_s4_day    <= n_s4_day;
            r_s4_hour   <= n_s4_hour;
            r_s4_minute <= n_s4_minute;
            r_s4_second <= n_s4_second;
            r_s4_over   <= n_s4_over;
        end
    end

    assign o_rsp.out_seconds_count = r_s4_count;
    assign o_rsp.out_year          = r_s4_year;
    assign o_rsp.out_month         = r_s4_month;
    assign o_rsp.out_day           = r_s4_day;
    assign o_rsp.out_hour          = r_s4_hour;
    assign o_rsp.out_minute        = r_s4_minute;
    assign o_rsp.out_second        = r_s4_second;
    assign o_rsp.out_range_error   = r_s4_over;

    // ---------------- checks
    `CSC_ASSERT_SAME(a_stall_only_when_full, !i_req.ready, o_rsp.valid && !o_rsp.ready, "input stalled while output side free")
    `CSC_ASSERT_NEXT(a_full_keeps_output, !i_req.ready, o_rsp.valid, "full pipeline lost its output beat")
    `CSC_ASSERT_SAME(a_range_saturates, o_rsp.valid && o_rsp.out_range_error, o_rsp.out_year == YEAR_W'(CENTURY_YEARS - 1) && o_rsp.out_month == MONTH_W'(MONTHS) && o_rsp.out_hour == HOUR_W'(23) && o_rsp.out_second == SEC_W'(59), "saturated count not at last second")
    `CSC_ASSERT_SAME(a_direction_split, o_rsp.valid && o_rsp.out_day != '0, o_rsp.out_seconds_count == '0 && o_rsp.out_month != '0, "date result mixed with count result")

endmodule

`default_nettype wire

// ===== design/csc_flow.sv =====
`default_nettype none

module csc_flow import csc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_ready,
    output t_pipe_ctl o_ctl
);

    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] n_vld;
    logic [PIPE_STAGES-1:0] load;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        load[PIPE_STAGES-1] = !r_vld[PIPE_STAGES-1] || i_out_ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            load[k] = !r_vld[k] || load[k+1];
        end
        n_vld[0] = load[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < PIPE_STAGES; k++) begin
            n_vld[k] = load[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctl.load = load;
    assign o_ctl.vld  = r_vld;

endmodule

`default_nettype wire

// ===== design/csc_date_count.sv =====
`default_nettype none

module csc_date_count import csc_pkg::*; (
    input  logic [YEAR_W-1:0]  i_year,
    input  logic [MONTH_W-1:0] i_month,
    input  logic [DAY_W-1:0]   i_day,
    input  logic [HOUR_W-1:0]  i_hour,
    input  logic [MIN_W-1:0]   i_minute,
    input  logic [SEC_W-1:0]   i_second,
    output logic [CNT_W-1:0]   o_count
);

    logic                 date_ok;
    logic                 leap;
    logic [MONTH_W-1:0]   m0;
    logic [DAYS_W-1:0]    days;
    logic [CNT_W-1:0]     count;

    assign date_ok = (i_month != '0) && (i_day != '0) && (i_month <= MONTH_W'(MONTHS));
    assign leap    = (i_year[1:0] == 2'b00);
    assign m0      = i_month - MONTH_W'(1);

    // year 0 is leap, so the leap days before year y number ceil(y / 4)
    assign days = DAYS_W'(i_year) * DAYS_W'(DAYS_PER_YEAR)
                + DAYS_W'((8'(i_year) + 8'd3) >> 2)
                + DAYS_W'(cum_days(m0, leap))
                + DAYS_W'(i_day) - DAYS_W'(1);

    assign count = CNT_W'(days) * CNT_W'(SECS_PER_DAY)
                 + CNT_W'(i_hour) * CNT_W'(SECS_PER_HOUR)
                 + CNT_W'(i_minute) * CNT_W'(SECS_PER_MIN)
                 + CNT_W'(i_second);

    assign o_count = date_ok ? count : '0;

endmodule

`default_nettype wire

// ===== design/csc_day_split.sv =====
`default_nettype none

module csc_day_split import csc_pkg::*; (
    input  logic [QUAD_W-1:0]  i_quad,
    input  logic [DOQ_W-1:0]   i_doq,
    output logic [YEAR_W-1:0]  o_year,
    output logic [MONTH_W-1:0] o_month,
    output logic [DAY_W-1:0]   o_day
);

    localparam logic [DOQ_W-1:0] Y1_START = DOQ_W'(DAYS_PER_YEAR) + DOQ_W'(1);
    localparam logic [DOQ_W-1:0] Y2_START = Y1_START + DOQ_W'(DAYS_PER_YEAR);
    localparam logic [DOQ_W-1:0] Y3_START = Y2_START + DOQ_W'(DAYS_PER_YEAR);

    logic [1:0]         yq;
    logic [DOY_W-1:0]   doy;
    logic               leap;
    logic [MONTH_W-1:0] m0;
    logic [DOY_W-1:0]   dm;

    always_comb begin
        // first year of each cycle is the leap one
        if (i_doq < Y1_START) begin
            yq  = 2'd0;
            doy = DOY_W'(i_doq);
        end else if (i_doq < Y2_START) begin
            yq  = 2'd1;
            doy = DOY_W'(i_doq - Y1_START);
        end else if (i_doq < Y3_START) begin
            yq  = 2'd2;
            doy = DOY_W'(i_doq - Y2_START);
        end else begin
            yq  = 2'd3;
            doy = DOY_W'(i_doq - Y3_START);
        end
        leap = (yq == 2'd0);

        m0 = '0;
        for (int k = 1; k < MONTHS; k++) begin
            if (doy >= cum_days(MONTH_W'(k), leap)) begin
                m0 = MONTH_W'(k);
            end
        end

        dm = doy - cum_days(m0, leap);
        if (dm > MAX_DAY_IDX) begin
            dm = MAX_DAY_IDX;
        end
    end

    assign o_year  = YEAR_W'({i_quad, yq});
    assign o_month = m0 + MONTH_W'(1);
    assign o_day   = DAY_W'(dm) + DAY_W'(1);

endmodule

`default_nettype wire
